// ===== hdl/prefix_match_symbol_table_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PREFIX_MATCH_SYMBOL_TABLE_ASSERT_SVH
`define PREFIX_MATCH_SYMBOL_TABLE_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define PMST_CHECK(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("pmst check failed");

// Check that a condition in one cycle implies another in the next.
`define PMST_CHECK_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("pmst sequence check failed");

`endif

// ===== hdl/pmst_pkg.sv =====
package pmst_pkg;

    localparam int TABLE_DEPTH    = 64;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = ADDR_W + 1;
    localparam int PTR_W          = ADDR_W + 2;
    localparam int MAX_NAME_CHARS = 16;
    localparam int LEN_W          = 5;
    localparam int VALUE_BITS     = 32;
    localparam int NAME_W         = 64;

    typedef enum logic [1:0] {
        CMD_LOOKUP, CMD_INSERT, CMD_REMOVE, CMD_SPARE
    } t_cmd;

    typedef enum logic [2:0] {
        STS_DONE, STS_NOT_FOUND, STS_AMBIGUOUS, STS_ILLEGAL, STS_EXISTS, STS_FULL
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE, KIND_AMBIG, KIND_EXACT
    } t_kind;

    typedef struct packed {
        logic [NAME_W-1:0]     lo;
        logic [NAME_W-1:0]     hi;
        logic [LEN_W-1:0]      len;
        logic [VALUE_BITS-1:0] val;
    } t_entry;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_ILLEGAL, OP_INIT, OP_PROBE, OP_STEP, OP_MISS,
        OP_EXACT, OP_WALK_DN, OP_WALK_READ, OP_WALK_STEP, OP_WALK_TURN,
        OP_SETTLE, OP_READ_SLOT, OP_APPLY, OP_SHU_READ, OP_SHU_WRITE,
        OP_SHD_READ, OP_SHD_WRITE, OP_PLACE, OP_DROP
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_LOOP, ST_PROBE_W, ST_MISS, ST_MATCH, ST_WALK,
        ST_WALK_W, ST_SETTLE, ST_FETCH, ST_APPLY, ST_SHU, ST_SHU_W, ST_SHD,
        ST_SHD_W, ST_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_ctl;

    typedef struct packed {
        logic legal;
        logic in_range;
        logic cmp_zero;
        logic exact_len;
        logic walk_in;
        logic dir_up;
        logic is_insert;
        logic is_remove;
        logic kind_exact;
        logic full;
        logic shu_more;
        logic shd_more;
    } t_dp_sts;

    // Collating rank: digits, then underscore, then lower-case letters.
    function automatic logic [5:0] coll_rank(input logic [7:0] c);
        logic [5:0] r;
        r = 6'd0;
        if (c >= "0" && c <= "9") r = 6'(c - "0") + 6'd1;
        else if (c == "_") r = 6'd11;
        else if (c >= "a" && c <= "z") r = 6'(c - "a") + 6'd12;
        return r;
    endfunction

endpackage

// ===== hdl/pmst_dp.sv =====
module pmst_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pmst_pkg::t_dp_ctl                   i_ctl,
    output pmst_pkg::t_dp_sts                   o_sts,
    input  logic [1:0]                          i_command,
    input  logic [63:0]                         i_name_chars_low,
    input  logic [63:0]                         i_name_chars_high,
    input  logic [4:0]                          i_name_length,
    input  logic [31:0]                         i_entry_value,
    input  logic                                i_replace_existing,
    output logic [2:0]                          o_status,
    output logic [31:0]                         o_found_value,
    output logic [5:0]                          o_first_index,
    output logic [5:0]                          o_last_index,
    output logic [6:0]                          o_entry_count
);
    localparam int PW = pmst_pkg::PTR_W;
    localparam int AW = pmst_pkg::ADDR_W;
    localparam int CW = pmst_pkg::CNT_W;

    pmst_pkg::t_entry r_mem [pmst_pkg::TABLE_DEPTH];
    pmst_pkg::t_entry r_rd;
    pmst_pkg::t_entry wr_data;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             rd_en, wr_en;

    pmst_pkg::t_cmd    r_cmd;
    logic [127:0]      r_q;
    logic [4:0]        r_q_len;
    logic [31:0]       r_val;
    logic              r_repl, r_legal;
    logic [CW-1:0]     r_count;
    logic signed [PW-1:0] r_first, r_last, r_slot, r_s;
    logic              r_dir, r_cmp_pos, r_exact_len;
    pmst_pkg::t_kind   r_kind;
    pmst_pkg::t_status r_status;
    logic [31:0]       r_fval;
    logic [5:0]        r_out_first, r_out_last;

    logic              n_legal;
    logic [127:0]      n_fold;
    logic [127:0]      in_name;
    logic signed [PW:0]   sum;
    logic signed [PW-1:0] mid, cnt_s, cmp_inc;
    logic              cmp_zero, cmp_pos;
    logic [4:0]        mism, lim, pos;
    logic [127:0]      en;

    assign in_name = {i_name_chars_high, i_name_chars_low};

    // Check and fold the incoming name.
    always_comb begin
        logic [7:0] c;
        logic       ok;
        n_legal = (i_name_length <= 5'(pmst_pkg::MAX_NAME_CHARS));
        n_fold  = '0;
        for (int i = 0; i < 16; i++) begin
            c  = in_name[i*8 +: 8];
            ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_") ||
                 (i > 0 && c >= "0" && c <= "9");
            if (5'(i) < i_name_length) begin
                if (!ok) n_legal = 1'b0;
                n_fold[i*8 +: 8] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            end
        end
    end

    // Prefix compare of the query against the entry just read.
    always_comb begin
        en   = {r_rd.hi, r_rd.lo};
        mism = 5'd16;
        for (int i = 15; i >= 0; i--) begin
            if (r_q[i*8 +: 8] != en[i*8 +: 8]) mism = 5'(i);
        end
        lim      = (r_q_len < r_rd.len) ? r_q_len : r_rd.len;
        pos      = (mism < lim) ? mism : lim;
        cmp_zero = (pos == r_q_len);
        cmp_pos  = !cmp_zero && ((pos == r_rd.len) ||
                   (pmst_pkg::coll_rank(r_q[{pos[3:0], 3'b000} +: 8]) >
                    pmst_pkg::coll_rank(en[{pos[3:0], 3'b000} +: 8])));
    end

    assign sum     = {r_first[PW-1], r_first} + {r_last[PW-1], r_last};
    assign mid     = sum[PW:1];
    assign cnt_s   = $signed({1'b0, r_count});
    assign cmp_inc = $signed({{(PW-1){1'b0}}, r_cmp_pos});

    // Select the memory read and write for the current operation.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_slot[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_s[AW-1:0];
        wr_data = r_rd;
        case (i_ctl.op)
            pmst_pkg::OP_PROBE:     rd_addr = mid[AW-1:0];
            pmst_pkg::OP_WALK_READ: rd_addr = r_s[AW-1:0];
            pmst_pkg::OP_READ_SLOT: rd_addr = r_slot[AW-1:0];
            pmst_pkg::OP_SHU_READ:  rd_addr = AW'(r_s - 1);
            pmst_pkg::OP_SHD_READ:  rd_addr = AW'(r_s + 1);
            pmst_pkg::OP_APPLY: begin
                rd_en   = 1'b0;
                wr_en   = (r_cmd == pmst_pkg::CMD_INSERT) &&
                          (r_kind == pmst_pkg::KIND_EXACT) && r_repl;
                wr_addr = r_slot[AW-1:0];
                wr_data = {r_rd.lo, r_rd.hi, r_rd.len, r_val};
            end
            pmst_pkg::OP_SHU_WRITE, pmst_pkg::OP_SHD_WRITE: begin
                rd_en = 1'b0;
                wr_en = 1'b1;
            end
            pmst_pkg::OP_PLACE: begin
                rd_en   = 1'b0;
                wr_en   = 1'b1;
                wr_addr = r_slot[AW-1:0];
                wr_data = {r_q[63:0], r_q[127:64], r_q_len, r_val};
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.op == pmst_pkg::OP_PLACE) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.op == pmst_pkg::OP_DROP) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Search pointers, request fields and result.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            pmst_pkg::OP_LOAD: begin
                r_cmd   <= pmst_pkg::t_cmd'(i_command);
                r_q     <= n_fold;
                r_q_len <= i_name_length;
                r_val   <= i_entry_value;
                r_repl  <= i_replace_existing;
                r_legal <= n_legal;
            end
            pmst_pkg::OP_ILLEGAL: begin
                r_status    <= pmst_pkg::STS_ILLEGAL;
                r_fval      <= '0;
                r_out_first <= '0;
                r_out_last  <= '0;
            end
            pmst_pkg::OP_INIT: begin
                r_first   <= '0;
                r_last    <= cnt_s - PW'(1);
                r_slot    <= '0;
                r_cmp_pos <= 1'b0;
            end
            pmst_pkg::OP_PROBE: r_slot <= mid;
            pmst_pkg::OP_STEP: begin
                r_cmp_pos <= cmp_pos;
                if (cmp_zero) begin
                    r_first     <= r_slot;
                    r_last      <= r_slot;
                    r_exact_len <= (r_rd.len == r_q_len);
                end else if (cmp_pos) begin
                    r_first <= r_slot + PW'(1);
                end else begin
                    r_last <= r_slot - PW'(1);
                end
            end
            pmst_pkg::OP_MISS: begin
                r_slot  <= r_slot + cmp_inc;
                r_first <= r_slot + cmp_inc;
                r_last  <= r_slot + cmp_inc;
                r_kind  <= pmst_pkg::KIND_NONE;
            end
            pmst_pkg::OP_EXACT: r_kind <= pmst_pkg::KIND_EXACT;
            pmst_pkg::OP_WALK_DN: begin
                r_s   <= r_slot - PW'(1);
                r_dir <= 1'b0;
            end
            pmst_pkg::OP_WALK_TURN: begin
                r_s   <= r_slot + PW'(1);
                r_dir <= 1'b1;
            end
            pmst_pkg::OP_WALK_STEP: begin
                if (cmp_zero && r_dir) begin
                    r_last <= r_s;
                    r_s    <= r_s + PW'(1);
                end else if (cmp_zero) begin
                    r_first <= r_s;
                    r_s     <= r_s - PW'(1);
                end else if (!r_dir) begin
                    r_s   <= r_slot + PW'(1);
                    r_dir <= 1'b1;
                end
            end
            pmst_pkg::OP_SETTLE: begin
                if (r_first == r_last) begin
                    r_kind <= pmst_pkg::KIND_EXACT;
                end else begin
                    r_kind <= pmst_pkg::KIND_AMBIG;
                    r_slot <= r_first;
                end
            end
            pmst_pkg::OP_APPLY: begin
                r_s    <= (r_cmd == pmst_pkg::CMD_INSERT) ? cnt_s : r_slot;
                r_fval <= '0;
                if (r_cmd == pmst_pkg::CMD_INSERT) begin
                    r_out_first <= r_slot[5:0];
                    r_out_last  <= r_slot[5:0];
                    if (r_kind == pmst_pkg::KIND_EXACT) begin
                        r_fval   <= r_rd.val;
                        r_status <= r_repl ? pmst_pkg::STS_DONE : pmst_pkg::STS_EXISTS;
                    end else if (o_sts.full) begin
                        r_status <= pmst_pkg::STS_FULL;
                    end else begin
                        r_status <= pmst_pkg::STS_DONE;
                    end
                end else begin
                    r_out_first <= r_first[5:0];
                    r_out_last  <= r_last[5:0];
                    case (r_kind)
                        pmst_pkg::KIND_NONE:  r_status <= pmst_pkg::STS_NOT_FOUND;
                        pmst_pkg::KIND_AMBIG: r_status <= pmst_pkg::STS_AMBIGUOUS;
                        default: begin
                            r_status <= pmst_pkg::STS_DONE;
                            r_fval   <= r_rd.val;
                        end
                    endcase
                end
            end
            pmst_pkg::OP_SHU_WRITE: r_s <= r_s - PW'(1);
            pmst_pkg::OP_SHD_WRITE: r_s <= r_s + PW'(1);
            default: ;
        endcase
    end

    // Status back to the controller.
    always_comb begin
        o_sts.legal      = r_legal;
        o_sts.in_range   = (r_first <= r_last);
        o_sts.cmp_zero   = cmp_zero;
        o_sts.exact_len  = r_exact_len;
        o_sts.walk_in    = r_dir ? (r_s < cnt_s) : (r_s >= 0);
        o_sts.dir_up     = r_dir;
        o_sts.is_insert  = (r_cmd == pmst_pkg::CMD_INSERT);
        o_sts.is_remove  = (r_cmd == pmst_pkg::CMD_REMOVE);
        o_sts.kind_exact = (r_kind == pmst_pkg::KIND_EXACT);
        o_sts.full       = (r_count >= CW'(pmst_pkg::TABLE_DEPTH));
        o_sts.shu_more   = (r_s > r_slot);
        o_sts.shd_more   = ((r_s + PW'(1)) < cnt_s);
    end

    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_first_index = r_out_first;
    assign o_last_index  = r_out_last;
    assign o_entry_count = r_count;

endmodule

// ===== hdl/pmst_ctrl.sv =====
module pmst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pmst_pkg::t_dp_sts i_sts,
    output pmst_pkg::t_dp_ctl o_ctl
);
    pmst_pkg::t_state r_state, n_state;

    // Hold the state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pmst_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Sequence one request through search, resolve and update.
    always_comb begin
        n_state     = r_state;
        o_ctl.op    = pmst_pkg::OP_IDLE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pmst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = pmst_pkg::OP_LOAD;
                    n_state  = pmst_pkg::ST_CHECK;
                end
            end
            pmst_pkg::ST_CHECK: begin
                if (!i_sts.legal) begin
                    o_ctl.op = pmst_pkg::OP_ILLEGAL;
                    n_state  = pmst_pkg::ST_DONE;
                end else begin
                    o_ctl.op = pmst_pkg::OP_INIT;
                    n_state  = pmst_pkg::ST_LOOP;
                end
            end
            pmst_pkg::ST_LOOP: begin
                if (i_sts.in_range) begin
                    o_ctl.op = pmst_pkg::OP_PROBE;
                    n_state  = pmst_pkg::ST_PROBE_W;
                end else begin
                    n_state = pmst_pkg::ST_MISS;
                end
            end
            pmst_pkg::ST_PROBE_W: begin
                o_ctl.op = pmst_pkg::OP_STEP;
                n_state  = i_sts.cmp_zero ? pmst_pkg::ST_MATCH : pmst_pkg::ST_LOOP;
            end
            pmst_pkg::ST_MISS: begin
                o_ctl.op = pmst_pkg::OP_MISS;
                n_state  = pmst_pkg::ST_FETCH;
            end
            pmst_pkg::ST_MATCH: begin
                if (i_sts.exact_len) begin
                    o_ctl.op = pmst_pkg::OP_EXACT;
                    n_state  = pmst_pkg::ST_FETCH;
                end else begin
                    o_ctl.op = pmst_pkg::OP_WALK_DN;
                    n_state  = pmst_pkg::ST_WALK;
                end
            end
            pmst_pkg::ST_WALK: begin
                if (i_sts.walk_in) begin
                    o_ctl.op = pmst_pkg::OP_WALK_READ;
                    n_state  = pmst_pkg::ST_WALK_W;
                end else if (!i_sts.dir_up) begin
                    o_ctl.op = pmst_pkg::OP_WALK_TURN;
                end else begin
                    n_state = pmst_pkg::ST_SETTLE;
                end
            end
            pmst_pkg::ST_WALK_W: begin
                o_ctl.op = pmst_pkg::OP_WALK_STEP;
                n_state  = (!i_sts.cmp_zero && i_sts.dir_up) ? pmst_pkg::ST_SETTLE
                                                             : pmst_pkg::ST_WALK;
            end
            pmst_pkg::ST_SETTLE: begin
                o_ctl.op = pmst_pkg::OP_SETTLE;
                n_state  = pmst_pkg::ST_FETCH;
            end
            pmst_pkg::ST_FETCH: begin
                o_ctl.op = pmst_pkg::OP_READ_SLOT;
                n_state  = pmst_pkg::ST_APPLY;
            end
            pmst_pkg::ST_APPLY: begin
                o_ctl.op = pmst_pkg::OP_APPLY;
                if (i_sts.is_insert && !i_sts.kind_exact && !i_sts.full)
                    n_state = pmst_pkg::ST_SHU;
                else if (i_sts.is_remove && i_sts.kind_exact)
                    n_state = pmst_pkg::ST_SHD;
                else
                    n_state = pmst_pkg::ST_DONE;
            end
            pmst_pkg::ST_SHU: begin
                if (i_sts.shu_more) begin
                    o_ctl.op = pmst_pkg::OP_SHU_READ;
                    n_state  = pmst_pkg::ST_SHU_W;
                end else begin
                    o_ctl.op = pmst_pkg::OP_PLACE;
                    n_state  = pmst_pkg::ST_DONE;
                end
            end
            pmst_pkg::ST_SHU_W: begin
                o_ctl.op = pmst_pkg::OP_SHU_WRITE;
                n_state  = pmst_pkg::ST_SHU;
            end
            pmst_pkg::ST_SHD: begin
                if (i_sts.shd_more) begin
                    o_ctl.op = pmst_pkg::OP_SHD_READ;
                    n_state  = pmst_pkg::ST_SHD_W;
                end else begin
                    o_ctl.op = pmst_pkg::OP_DROP;
                    n_state  = pmst_pkg::ST_DONE;
                end
            end
            pmst_pkg::ST_SHD_W: begin
                o_ctl.op = pmst_pkg::OP_SHD_WRITE;
                n_state  = pmst_pkg::ST_SHD;
            end
            pmst_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = pmst_pkg::ST_IDLE;
            end
            default: n_state = pmst_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/prefix_match_symbol_table.sv =====
// Prefix-match symbol table of up to 64 names of up to 16 characters.
// Request channel: i_in_valid / o_in_ready carry command, name, length,
// value and replace flag. Result channel: o_out_valid / i_out_ready carry
// status, found value, first and last index and the entry count.
// One request is in flight at a time: o_in_ready is high only when idle.
// Latency is shortest for an illegal name and grows with the binary search
// over the N entries, with W, the number of neighbors checked on a partial
// match, and with S, the entries shifted by an insert or remove. Each probe,
// walk step and shift step reads the table memory and then uses the read
// data in a separate state; the worst case is an ambiguous insert into a
// 63-entry table.
// Reset clears the entry count; table contents need no clearing since data
// read from entries at or above the count is never used.
// The result is held in output registers while i_out_ready is low, and
// no new request is taken until it is accepted.
module prefix_match_symbol_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_name_chars_low,
    input  logic [63:0] i_name_chars_high,
    input  logic [4:0]  i_name_length,
    input  logic [31:0] i_entry_value,
    input  logic        i_replace_existing,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_value,
    output logic [5:0]  o_first_index,
    output logic [5:0]  o_last_index,
    output logic [6:0]  o_entry_count
);
    pmst_pkg::t_dp_ctl ctl;
    pmst_pkg::t_dp_sts sts;

    pmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    pmst_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_command          (i_command),
        .i_name_chars_low   (i_name_chars_low),
        .i_name_chars_high  (i_name_chars_high),
        .i_name_length      (i_name_length),
        .i_entry_value      (i_entry_value),
        .i_replace_existing (i_replace_existing),
        .o_status           (o_status),
        .o_found_value      (o_found_value),
        .o_first_index      (o_first_index),
        .o_last_index       (o_last_index),
        .o_entry_count      (o_entry_count)
    );

endmodule

// ===== hdl/pmst_checker.sv =====
`include "prefix_match_symbol_table_assert.svh"

module pmst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [31:0] o_found_value,
    input logic [5:0]  o_first_index,
    input logic [5:0]  o_last_index,
    input logic [6:0]  o_entry_count
);
    // Hold a result until it is taken.
    `PMST_CHECK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status))
    // Take no request while a result waits.
    `PMST_CHECK(a_one_in_flight, !(o_in_ready && o_out_valid))
    // Report an illegal name with zero indexes and no value.
    `PMST_CHECK(a_illegal_clean, !(o_out_valid && o_status == pmst_pkg::STS_ILLEGAL) || (o_first_index == 6'd0 && o_last_index == 6'd0 && o_found_value == 32'd0))
    // Never count past the table size.
    `PMST_CHECK(a_count_bound, o_entry_count <= 7'd64)
    // Hold the count while idle with no request.
    `PMST_CHECK_NEXT(a_count_step, o_in_ready && !i_in_valid, $stable(o_entry_count))

endmodule

bind prefix_match_symbol_table pmst_checker u_pmst_checker (.*);
